// ===== rtl/core/acq_pkg.sv =====
// ----------------------------------------------------------------------------
// acq_pkg
// Shared types and constants for the box table and its overlap query.
// ----------------------------------------------------------------------------
package acq_pkg;

  localparam int IDX_W       = 5;   // model_index and hit_index width
  localparam int MC_W        = 6;   // model_count register width
  localparam int CMP_W       = 8;   // common width for index and count compares
  localparam int MAX_HITS    = 31;  // cap on hits reported by one query
  localparam int HIT_CNT_W   = 5;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_ENABLE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // What the front hands the back for each word that survives classification
  typedef enum logic [1:0] {
    K_VERTEX = 2'd0,
    K_ENABLE = 2'd1,
    K_QUERY  = 2'd2,
    K_MISS   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] idx;
    logic             first;
    logic             en_val;
  } item_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] hit_index;
    logic             hit_valid;
    logic             last_result;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VTX_UPD,
    ST_Q_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FINISH
  } back_state_e;

endpackage

// ===== rtl/core/aabb_collider_table_query.sv =====
// ----------------------------------------------------------------------------
// aabb_collider_table_query
// Table of per-model axis-aligned boxes with enable flags and a brute-force
// overlap query.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid_i / in_stall_o: vertex words grow a model's
// box, enable words set a model's flag, query words list the enabled models
// whose boxes overlap the queried one. Result words leave on out_valid_o /
// out_stall_i, one per hit, or a single no-hit word; last_result_o marks the
// final word of each query. cfg_we_i writes model_count at any idle time.
// A four-entry queue decouples the input from the executing back end, so
// words are taken while a result waits. The back end handles an enable word
// or a first vertex as it takes it from the queue, a growing vertex as a
// memory read, then a write, and a query on a disabled or out-of-range
// model by going straight to its no-hit word. Any other query reads the
// queried box, then reads the box of each enabled model other than the
// queried one in turn through the one box memory read port.
// While the receiver stalls, the output word holds and the scan waits at the
// next hit. Reset clears the enable flags, model_count and the queue; boxes
// are undefined until their first vertex is written.
// ----------------------------------------------------------------------------
module aabb_collider_table_query #(
  parameter int MAX_MODELS = 32,
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [acq_pkg::MC_W-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [acq_pkg::IDX_W-1:0]    model_index_i,
  input  logic signed [31:0]           vertex_x_i,
  input  logic signed [31:0]           vertex_y_i,
  input  logic signed [31:0]           vertex_z_i,
  input  logic                         first_vertex_i,
  input  logic                         enable_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [acq_pkg::IDX_W-1:0]    hit_index_o,
  output logic                         hit_valid_o,
  output logic                         last_result_o
);
  import acq_pkg::*;

  localparam int KEY_W   = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int ENTRY_W = $bits(item_ctl_t) + 3*KEY_W;

  logic [MC_W-1:0]    model_count_q;
  logic [CMP_W-1:0]   mc_ext, act_cnt;
  logic               push, q_full, q_empty, q_pop;
  item_ctl_t          front_ctl, head_ctl;
  logic [3*KEY_W-1:0] front_keys, head_keys;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  result_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_count_q <= '0;
    end else if (cfg_we_i) begin
      model_count_q <= cfg_wdata_i;
    end
  end

  // counts above the table size act as the table size
  assign mc_ext  = {{(CMP_W-MC_W){1'b0}}, model_count_q};
  assign act_cnt = (mc_ext > CMP_W'(MAX_MODELS)) ? CMP_W'(MAX_MODELS) : mc_ext;

  acq_front #(
    .MAX_MODELS (MAX_MODELS),
    .KEY_W      (KEY_W)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .model_index_i  (model_index_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .vertex_z_i     (vertex_z_i),
    .first_vertex_i (first_vertex_i),
    .enable_value_i (enable_value_i),
    .act_cnt_i      (act_cnt),
    .q_full_i       (q_full),
    .push_o         (push),
    .ctl_o          (front_ctl),
    .keys_o         (front_keys)
  );

  assign q_wdata = {front_ctl, front_keys};
  assign {head_ctl, head_keys} = q_rdata;

  acq_fifo #(
    .DATA_W (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  acq_back #(
    .MAX_MODELS (MAX_MODELS),
    .KEY_W      (KEY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .act_cnt_i   (act_cnt),
    .q_empty_i   (q_empty),
    .q_ctl_i     (head_ctl),
    .q_keys_i    (head_keys),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign hit_index_o   = res.hit_index;
  assign hit_valid_o   = res.hit_valid;
  assign last_result_o = res.last_result;

endmodule

// ===== rtl/core/acq_fifo.sv =====
// ----------------------------------------------------------------------------
// acq_fifo
// Short queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module acq_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);
  import acq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]    count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = (PTR_W+1)'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = (PTR_W+1)'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/acq_front.sv =====
// ----------------------------------------------------------------------------
// acq_front
// Input side: take words, turn coordinates into compare keys, drop words
// that change nothing and mark queries that can only miss.
// ----------------------------------------------------------------------------
module acq_front #(
  parameter int MAX_MODELS = 32,
  parameter int KEY_W      = 32
) (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [acq_pkg::IDX_W-1:0]      model_index_i,
  input  logic signed [31:0]             vertex_x_i,
  input  logic signed [31:0]             vertex_y_i,
  input  logic signed [31:0]             vertex_z_i,
  input  logic                           first_vertex_i,
  input  logic                           enable_value_i,
  input  logic [acq_pkg::CMP_W-1:0]      act_cnt_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output acq_pkg::item_ctl_t             ctl_o,
  output logic [3*KEY_W-1:0]             keys_o
);
  import acq_pkg::*;

  logic [CMP_W-1:0] idx_ext;
  logic             keep;

  assign idx_ext    = {{(CMP_W-IDX_W){1'b0}}, model_index_i};
  assign in_stall_o = q_full_i;
  // keep the low key bits only: narrow coordinates wrap to signed KEY_W
  assign keys_o     = {vertex_z_i[KEY_W-1:0], vertex_y_i[KEY_W-1:0],
                       vertex_x_i[KEY_W-1:0]};

  always_comb begin
    keep         = 1'b0;
    ctl_o.kind   = K_VERTEX;
    ctl_o.idx    = model_index_i;
    ctl_o.first  = first_vertex_i;
    ctl_o.en_val = enable_value_i;
    case (op_e'(op_i))
      OP_VERTEX: begin
        keep = (idx_ext < CMP_W'(MAX_MODELS));
      end
      OP_ENABLE: begin
        ctl_o.kind = K_ENABLE;
        keep       = (idx_ext < act_cnt_i);
      end
      OP_QUERY: begin
        ctl_o.kind = (idx_ext < act_cnt_i) ? K_QUERY : K_MISS;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && !q_full_i && keep;

endmodule

// ===== rtl/core/acq_back.sv =====
// ----------------------------------------------------------------------------
// acq_back
// Execution side: box memory, enable flags, the overlap scan and the
// output register.
// ----------------------------------------------------------------------------
module acq_back #(
  parameter int MAX_MODELS = 32,
  parameter int KEY_W      = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [acq_pkg::CMP_W-1:0] act_cnt_i,
  input  logic                      q_empty_i,
  input  acq_pkg::item_ctl_t        q_ctl_i,
  input  logic [3*KEY_W-1:0]        q_keys_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output acq_pkg::result_t          res_o
);
  import acq_pkg::*;

  localparam int ADDR_W = $clog2(MAX_MODELS);
  localparam int CNT_W  = $clog2(MAX_MODELS + 1);
  localparam int WORD_W = 6 * KEY_W;  // {hi z,y,x, lo z,y,x}

  back_state_e         state_q, state_d;
  logic [ADDR_W-1:0]   cur_addr_q, cur_addr_d;
  logic [3*KEY_W-1:0]  cur_keys_q;
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic [HIT_CNT_W-1:0] hits_q, hits_d;
  logic                pend_v_q, pend_v_d;
  logic [IDX_W-1:0]    pend_idx_q, pend_idx_d;
  logic [MAX_MODELS-1:0] enable_q, enable_d;
  logic [WORD_W-1:0]   qbox_q;
  logic [WORD_W-1:0]   rd_q;
  logic [WORD_W-1:0]   box_mem_q [MAX_MODELS];
  logic                out_valid_q;
  result_t             res_q;

  logic                rd_en, wr_en, keys_load, qbox_load, out_load, out_free;
  logic [ADDR_W-1:0]   rd_addr, wr_addr, head_addr, scan_addr;
  logic [WORD_W-1:0]   wr_data, grown;
  logic [CMP_W-1:0]    head_ext, scan_ext;
  logic                overlap;
  result_t             res_d;

  assign head_ext  = {{(CMP_W-IDX_W){1'b0}}, q_ctl_i.idx};
  assign head_addr = head_ext[ADDR_W-1:0];
  assign scan_ext  = {{(CMP_W-CNT_W){1'b0}}, scan_q};
  assign scan_addr = scan_q[ADDR_W-1:0];
  assign out_free  = !out_valid_q || !out_stall_i;

  // grow the stored box by the held vertex, one axis per slice
  always_comb begin
    logic [KEY_W-1:0] k, lo, hi;
    for (int a = 0; a < 3; a++) begin
      k  = cur_keys_q[a*KEY_W +: KEY_W];
      lo = rd_q[a*KEY_W +: KEY_W];
      hi = rd_q[(3+a)*KEY_W +: KEY_W];
      grown[a*KEY_W +: KEY_W]     = ($signed(k) < $signed(lo)) ? k : lo;
      grown[(3+a)*KEY_W +: KEY_W] = ($signed(k) > $signed(hi)) ? k : hi;
    end
  end

  // inclusive overlap of the queried box with the box just read
  always_comb begin
    logic [KEY_W-1:0] qlo, qhi, blo, bhi;
    overlap = 1'b1;
    for (int a = 0; a < 3; a++) begin
      qlo = qbox_q[a*KEY_W +: KEY_W];
      qhi = qbox_q[(3+a)*KEY_W +: KEY_W];
      blo = rd_q[a*KEY_W +: KEY_W];
      bhi = rd_q[(3+a)*KEY_W +: KEY_W];
      overlap = overlap && ($signed(qlo) <= $signed(bhi))
                        && ($signed(qhi) >= $signed(blo));
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_addr_d = cur_addr_q;
    scan_d     = scan_q;
    hits_d     = hits_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    enable_d   = enable_q;
    q_pop_o    = 1'b0;
    keys_load  = 1'b0;
    qbox_load  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_addr;
    wr_en      = 1'b0;
    wr_addr    = head_addr;
    wr_data    = {q_keys_i, q_keys_i};
    out_load   = 1'b0;
    res_d      = res_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o    = 1'b1;
          keys_load  = 1'b1;
          cur_addr_d = head_addr;
          case (q_ctl_i.kind)
            K_VERTEX: begin
              if (q_ctl_i.first) begin
                wr_en = 1'b1;
              end else begin
                rd_en   = 1'b1;
                state_d = ST_VTX_UPD;
              end
            end
            K_ENABLE: begin
              enable_d[head_addr] = q_ctl_i.en_val;
            end
            K_QUERY: begin
              pend_v_d = 1'b0;
              hits_d   = '0;
              scan_d   = '0;
              if (enable_q[head_addr]) begin
                rd_en   = 1'b1;
                state_d = ST_Q_LOAD;
              end else begin
                state_d = ST_FINISH;
              end
            end
            K_MISS: begin
              pend_v_d = 1'b0;
              state_d  = ST_FINISH;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_VTX_UPD: begin
        wr_en   = 1'b1;
        wr_addr = cur_addr_q;
        wr_data = grown;
        state_d = ST_IDLE;
      end
      ST_Q_LOAD: begin
        qbox_load = 1'b1;
        state_d   = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (scan_ext >= act_cnt_i || hits_q == HIT_CNT_W'(MAX_HITS)) begin
          state_d = ST_FINISH;
        end else if (scan_addr == cur_addr_q || !enable_q[scan_addr]) begin
          scan_d = CNT_W'(scan_q + 1'b1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_addr;
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (!overlap) begin
          scan_d  = CNT_W'(scan_q + 1'b1);
          state_d = ST_SCAN_RD;
        end else if (!pend_v_q || out_free) begin
          // a new hit proves the held one is not the last
          if (pend_v_q) begin
            out_load          = 1'b1;
            res_d.hit_index   = pend_idx_q;
            res_d.hit_valid   = 1'b1;
            res_d.last_result = 1'b0;
          end
          pend_v_d   = 1'b1;
          pend_idx_d = scan_ext[IDX_W-1:0];
          hits_d     = HIT_CNT_W'(hits_q + 1'b1);
          scan_d     = CNT_W'(scan_q + 1'b1);
          state_d    = ST_SCAN_RD;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load          = 1'b1;
          res_d.hit_index   = pend_v_q ? pend_idx_q : '0;
          res_d.hit_valid   = pend_v_q;
          res_d.last_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      hits_q      <= '0;
      pend_v_q    <= 1'b0;
      enable_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      hits_q      <= hits_d;
      pend_v_q    <= pend_v_d;
      enable_q    <= enable_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_addr_q <= cur_addr_d;
    pend_idx_q <= pend_idx_d;
    if (keys_load) begin
      cur_keys_q <= q_keys_i;
    end
    if (qbox_load) begin
      qbox_q <= rd_q;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  // box memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      box_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= box_mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/acq_checker.sv =====
// ----------------------------------------------------------------------------
// acq_checker
// Port-level checks on the result channel of the box query block.
// ----------------------------------------------------------------------------
module acq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [acq_pkg::IDX_W-1:0] hit_index_o,
  input logic                      hit_valid_o,
  input logic                      last_result_o
);
  import acq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(hit_index_o) && $stable(hit_valid_o) && $stable(last_result_o))
    else $error("stalled result word changed");

  a_nohit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_valid_o |-> last_result_o)
    else $error("no-hit word not marked last");

  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_valid_o |-> hit_index_o == '0)
    else $error("no-hit word carries an index");

  // a query never reports the same model twice in a row
  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && hit_valid_o && !last_result_o ##1
      out_valid_o |-> hit_valid_o && hit_index_o != $past(hit_index_o))
    else $error("hit repeated within a query");

endmodule

bind aabb_collider_table_query acq_checker u_acq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .hit_index_o   (hit_index_o),
  .hit_valid_o   (hit_valid_o),
  .last_result_o (last_result_o)
);

// ===== verif/aabb_overlap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_overlap_checker
// Watches both word channels and the count register of the box table, keeps
// its own copy of the boxes, enable flags and model count, works out the hit
// words each query must give and compares every result word with them.
// ----------------------------------------------------------------------------
module aabb_overlap_checker #(
  parameter int MODELS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [acq_pkg::MC_W-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [1:0]                 op_i,
  input  logic [acq_pkg::IDX_W-1:0]  model_index_i,
  input  logic signed [31:0]         vertex_x_i,
  input  logic signed [31:0]         vertex_y_i,
  input  logic signed [31:0]         vertex_z_i,
  input  logic                       first_vertex_i,
  input  logic                       enable_value_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [acq_pkg::IDX_W-1:0]  hit_index_i,
  input  logic                       hit_valid_i,
  input  logic                       last_result_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import acq_pkg::*;

  logic signed [31:0] lo_x [MODELS];
  logic signed [31:0] lo_y [MODELS];
  logic signed [31:0] lo_z [MODELS];
  logic signed [31:0] hi_x [MODELS];
  logic signed [31:0] hi_y [MODELS];
  logic signed [31:0] hi_z [MODELS];
  logic [MODELS-1:0]  enabled;
  logic [MC_W-1:0]    model_count;
  result_t            expected_hits [$];
  int                 mismatches = 0;

  function automatic int active_models();
    return (model_count > MODELS) ? MODELS : int'(model_count);
  endfunction

  // Inclusive on every axis: touching faces count as overlap
  function automatic logic boxes_touch(int a, int b);
    return lo_x[a] <= hi_x[b] && hi_x[a] >= lo_x[b] &&
           lo_y[a] <= hi_y[b] && hi_y[a] >= lo_y[b] &&
           lo_z[a] <= hi_z[b] && hi_z[a] >= lo_z[b];
  endfunction

  task automatic grow_box(int m, logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] z, logic first);
    if (first) begin
      lo_x[m] = x; hi_x[m] = x;
      lo_y[m] = y; hi_y[m] = y;
      lo_z[m] = z; hi_z[m] = z;
    end else begin
      if (x < lo_x[m]) lo_x[m] = x;
      if (x > hi_x[m]) hi_x[m] = x;
      if (y < lo_y[m]) lo_y[m] = y;
      if (y > hi_y[m]) hi_y[m] = y;
      if (z < lo_z[m]) lo_z[m] = z;
      if (z > hi_z[m]) hi_z[m] = z;
    end
  endtask

  task automatic predict_query(int q);
    int      hits [$];
    int      act;
    int      i;
    result_t word;
    act = active_models();
    if (q < act && enabled[q]) begin
      for (i = 0; i < act && hits.size() < MAX_HITS; i++) begin
        if (i != q && enabled[i] && boxes_touch(q, i)) hits = {hits, i};
      end
    end
    if (hits.size() == 0) begin
      word = '0;
      word.last_result = 1'b1;
      expected_hits = {expected_hits, word};
    end else begin
      for (i = 0; i < hits.size(); i++) begin
        word.hit_index   = IDX_W'(hits[i]);
        word.hit_valid   = 1'b1;
        word.last_result = (i == hits.size() - 1);
        expected_hits = {expected_hits, word};
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      enabled     = '0;
      model_count = '0;
      expected_hits.delete();
      mismatches  = 0;
    end else begin
      // Retire the result word first: a query taken at this edge cannot
      // have produced it
      if (out_valid_i && !out_stall_i) begin
        got.hit_index   = hit_index_i;
        got.hit_valid   = hit_valid_i;
        got.last_result = last_result_i;
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected hit word: index %0d valid %b last %b",
                     $time, got.hit_index, got.hit_valid, got.last_result);
        end else begin
          want = expected_hits.pop_front();
          if (got.hit_index !== want.hit_index || got.hit_valid !== want.hit_valid ||
              got.last_result !== want.last_result) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] hit word mismatch: expected index %0d valid %b last %b, %s",
                       $time, want.hit_index, want.hit_valid, want.last_result,
                       $sformatf("got index %0d valid %b last %b",
                                 got.hit_index, got.hit_valid, got.last_result));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_e'(op_i))
          OP_VERTEX: grow_box(int'(model_index_i), vertex_x_i, vertex_y_i, vertex_z_i,
                              first_vertex_i);
          OP_ENABLE: if (model_index_i < active_models())
                       enabled[model_index_i] = enable_value_i;
          OP_QUERY:  predict_query(int'(model_index_i));
          default:   ;
        endcase
      end
      if (cfg_we_i) model_count = cfg_wdata_i;
    end
    fail_count_o = mismatches;
    pending_o    = expected_hits.size();
  end

endmodule

// ===== verif/aabb_collider_table_query_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_collider_table_query_test
// Drives vertex, enable and query words into the box table, first a directed
// set around touching, disjoint, disabled and out-of-range cases, then random
// box sequences under several model counts, with random stalls on both sides,
// one long receiver hold-off and a quiet stretch. A checker beside the block
// predicts and compares the hit words.
// ----------------------------------------------------------------------------
module aabb_collider_table_query_test;
  import acq_pkg::*;

  localparam int MODELS        = 32;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] C_MAX = 32'h7fff_ffff;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [MC_W-1:0]    cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic [1:0]         op_i           = '0;
  logic [IDX_W-1:0]   model_index_i  = '0;
  logic [31:0]        vertex_x_i     = '0;
  logic [31:0]        vertex_y_i     = '0;
  logic [31:0]        vertex_z_i     = '0;
  logic               first_vertex_i = 1'b0;
  logic               enable_value_i = 1'b0;
  logic               out_stall_i    = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [IDX_W-1:0]   hit_index_o;
  logic               hit_valid_o;
  logic               last_result_o;

  int                 fail_count;
  int                 pending;
  logic [MODELS-1:0]  box_loaded  = '0;
  int                 words_sent  = 0;
  int                 in_gap_pct  = 18;
  int                 out_gap_pct = 18;
  logic               hold_arm    = 1'b0;
  logic               hold_done   = 1'b0;
  int                 hold_left   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  aabb_collider_table_query u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .model_index_i  (model_index_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .vertex_z_i     (vertex_z_i),
    .first_vertex_i (first_vertex_i),
    .enable_value_i (enable_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_index_o    (hit_index_o),
    .hit_valid_o    (hit_valid_o),
    .last_result_o  (last_result_o)
  );

  aabb_overlap_checker #(.MODELS(MODELS)) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .op_i           (op_i),
    .model_index_i  (model_index_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .vertex_z_i     (vertex_z_i),
    .first_vertex_i (first_vertex_i),
    .enable_value_i (enable_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_index_i    (hit_index_o),
    .hit_valid_i    (hit_valid_o),
    .last_result_i  (last_result_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Receiver: random stalls, plus one long hold-off once armed
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_gap_pct);
      end
    end
  end

  task automatic send_word(op_e op, logic [IDX_W-1:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic first, logic en);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    model_index_i  <= idx;
    vertex_x_i     <= x;
    vertex_y_i     <= y;
    vertex_z_i     <= z;
    first_vertex_i <= first;
    enable_value_i <= en;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_VERTEX) box_loaded[idx] = 1'b1;
    if (op != OP_NONE) words_sent++;
  endtask

  // Hold the input off until every expected hit word has come
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  task automatic set_count(int value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= MC_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord(logic [31:0] near);
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? C_MIN : C_MAX;
      1:       return $urandom;
      default: return near + 32'($urandom_range(32'h0003_0000)) - 32'h0001_8000;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_model(int count);
    if (count > 0 && $urandom_range(9) != 0) return IDX_W'($urandom_range(count - 1));
    return IDX_W'($urandom_range(MODELS - 1));
  endfunction

  // One box: a start vertex (or a growth of a loaded box), then up to two more
  task automatic send_box(logic [IDX_W-1:0] m);
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic        first;
    cx = 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
    cy = 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
    cz = 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
    first = !box_loaded[m] || $urandom_range(3) != 0;
    send_word(OP_VERTEX, m, pick_coord(cx), pick_coord(cy), pick_coord(cz), first,
              1'($urandom_range(1)));
    repeat ($urandom_range(2))
      send_word(OP_VERTEX, m, pick_coord(cx), pick_coord(cy), pick_coord(cz), 1'b0,
                1'($urandom_range(1)));
  endtask

  task automatic run_random(int count, int n_words);
    int               stop;
    int               r;
    logic [IDX_W-1:0] m;
    stop = words_sent + n_words;
    while (words_sent < stop) begin
      r = $urandom_range(99);
      m = pick_model(count);
      if (r < 40)
        send_box(m);
      else if (r < 58)
        send_word(OP_ENABLE, m, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                  box_loaded[m] && $urandom_range(3) != 0);
      else if (r < 95)
        send_word(OP_QUERY, m, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      else
        send_word(OP_NONE, m, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    end
  endtask

  initial begin
    int count;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Count still zero: query out of range, boxes load anyway, enable dropped
    send_word(OP_QUERY,  5'd0,  '0, '0, '0, 1'b0, 1'b0);
    send_word(OP_VERTEX, 5'd0,  C_MIN, C_MIN, C_MIN, 1'b1, 1'b0);
    send_word(OP_VERTEX, 5'd0,  C_MAX, C_MAX, C_MAX, 1'b0, 1'b1);
    send_word(OP_VERTEX, 5'd31, '0, '0, '0, 1'b1, 1'b0);
    send_word(OP_ENABLE, 5'd0,  '0, '0, '0, 1'b0, 1'b1);
    send_word(OP_NONE,   5'd7,  C_MAX, C_MIN, Q_ONE, 1'b1, 1'b1);

    set_count(MODELS);
    send_word(OP_QUERY,  5'd0,  '0, '0, '0, 1'b0, 1'b0);
    send_word(OP_ENABLE, 5'd0,  '0, '0, '0, 1'b0, 1'b1);
    send_word(OP_ENABLE, 5'd31, '0, '0, '0, 1'b0, 1'b1);
    send_word(OP_QUERY,  5'd0,  '0, '0, '0, 1'b0, 1'b0);
    // Model 2 touches model 1 at a corner; model 3 clears both on z
    send_word(OP_VERTEX, 5'd1,  Q_ONE, '0, '0, 1'b1, 1'b0);
    send_word(OP_VERTEX, 5'd1,  2 * Q_ONE, Q_ONE, Q_ONE, 1'b0, 1'b0);
    send_word(OP_VERTEX, 5'd2,  2 * Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b0);
    send_word(OP_VERTEX, 5'd3,  Q_ONE, '0, 2 * Q_ONE + 1, 1'b1, 1'b0);
    send_word(OP_ENABLE, 5'd1,  '0, '0, '0, 1'b0, 1'b1);
    send_word(OP_ENABLE, 5'd2,  '0, '0, '0, 1'b0, 1'b1);
    send_word(OP_ENABLE, 5'd3,  '0, '0, '0, 1'b0, 1'b1);
    send_word(OP_QUERY,  5'd1,  '0, '0, '0, 1'b0, 1'b0);
    send_word(OP_ENABLE, 5'd0,  '0, '0, '0, 1'b0, 1'b0);
    send_word(OP_QUERY,  5'd3,  '0, '0, '0, 1'b0, 1'b0);
    send_word(OP_QUERY,  5'd0,  '0, '0, '0, 1'b0, 1'b0);

    set_count(1);
    send_word(OP_QUERY,  5'd1,  '0, '0, '0, 1'b0, 1'b0);
    send_word(OP_ENABLE, 5'd0,  '0, '0, '0, 1'b0, 1'b1);
    send_word(OP_QUERY,  5'd0,  '0, '0, '0, 1'b0, 1'b0);
    send_word(OP_ENABLE, 5'd1,  '0, '0, '0, 1'b0, 1'b0);

    set_count(MODELS);
    run_random(MODELS, 60);

    count = $urandom_range(31, 2);
    set_count(count);
    run_random(count, 50);

    // Long receiver hold-off fills the block; then pause the sender mid-phase
    set_count(MODELS);
    hold_arm = 1'b1;
    run_random(MODELS, 25);
    drain();
    run_random(MODELS, 25);

    // Quiet stretch: no idling on either side
    set_count(MODELS);
    in_gap_pct  = 0;
    out_gap_pct = 0;
    run_random(MODELS, 60);
    in_gap_pct  = 18;
    out_gap_pct = 18;

    set_count(0);
    run_random(0, 20);

    count = $urandom_range(MODELS, 1);
    set_count(count);
    run_random(count, 30);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== aabb_collider_table_query.f =====
rtl/core/acq_pkg.sv
rtl/core/acq_fifo.sv
rtl/core/acq_front.sv
rtl/core/acq_back.sv
rtl/core/aabb_collider_table_query.sv
rtl/core/acq_checker.sv
verif/aabb_overlap_checker.sv
verif/aabb_collider_table_query_test.sv
